[design/prq_pkg.sv]
// types and constants shared by the priority ready queue modules
// no dependencies
package prq_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_LOOP,
        S_INS_PUT0,
        S_REM_HEAD,
        S_REM_LOOP,
        S_FIN
    } t_prq_state;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_prq_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_prq_op;

    typedef enum logic [1:0] {
        RD_LAST,
        RD_ZERO,
        RD_DEC,
        RD_INC
    } t_prq_rd_sel;

    typedef enum logic [1:0] {
        WA_ZERO,
        WA_INC,
        WA_DEC
    } t_prq_wa_sel;

    typedef enum logic {
        WD_NEW,
        WD_READ
    } t_prq_wd_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic        capture;
        logic        rd_en;
        t_prq_rd_sel rd_sel;
        logic        wr_en;
        t_prq_wa_sel wa_sel;
        t_prq_wd_sel wd_sel;
        logic        set_status;
        t_prq_status status;
        logic        take_head;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        out_load;
    } t_prq_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic count_one;
        logic lower;
        logic idx_zero;
        logic idx_last;
        logic out_busy;
    } t_prq_stat;

    localparam int unsigned IdBits     = 4;
    localparam int unsigned OutPriBits = 8;
    localparam int unsigned CountBits  = 5;

endpackage

[design/prq_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module prq_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/prq_datapath.sv]
// datapath: sorted entry store, count, index, result and output registers
// depends on prq_pkg and prq_ram
module prq_datapath #(
    parameter int unsigned QUEUE_DEPTH   = 16,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  prq_pkg::t_prq_cmd    i_cmd_bus,
    output prq_pkg::t_prq_stat   o_stat,
    input  logic                 i_cmd,
    input  logic [3:0]           i_proc_id,
    input  logic [7:0]           i_priority_req,
    input  logic                 i_res_stall,
    output logic                 o_res_valid,
    output logic                 o_out_valid,
    output logic [3:0]           o_out_proc_id,
    output logic [7:0]           o_out_priority,
    output logic [1:0]           o_status,
    output logic [4:0]           o_entry_count
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = prq_pkg::IdBits + PRIORITY_BITS;

    logic                          r_op;
    logic [prq_pkg::IdBits-1:0]    r_new_id;
    logic [PRIORITY_BITS-1:0]      r_new_pri;
    logic [CW-1:0]                 r_count;
    logic [AW-1:0]                 r_idx;
    logic [AW-1:0]                 n_idx;

    logic                          r_res_ok;
    logic [prq_pkg::IdBits-1:0]    r_res_id;
    logic [PRIORITY_BITS-1:0]      r_res_pri;
    prq_pkg::t_prq_status          r_res_status;

    logic                          r_o_valid;
    logic                          r_o_ok;
    logic [prq_pkg::IdBits-1:0]    r_o_id;
    logic [prq_pkg::OutPriBits-1:0] r_o_pri;
    prq_pkg::t_prq_status          r_o_status;
    logic [prq_pkg::CountBits-1:0] r_o_count;

    logic [AW-1:0]                 last_idx;
    logic [AW-1:0]                 wr_addr;
    logic [EW-1:0]                 wr_data;
    logic [EW-1:0]                 rd_data;
    logic [PRIORITY_BITS-1:0]      rd_pri;
    logic [prq_pkg::IdBits-1:0]    rd_id;

    assign last_idx = AW'(r_count - CW'(1));
    assign rd_pri   = rd_data[PRIORITY_BITS-1:0];
    assign rd_id    = rd_data[EW-1:PRIORITY_BITS];

    always_comb begin
        unique case (i_cmd_bus.rd_sel)
            prq_pkg::RD_LAST: n_idx = last_idx;
            prq_pkg::RD_ZERO: n_idx = '0;
            prq_pkg::RD_DEC:  n_idx = r_idx - AW'(1);
            prq_pkg::RD_INC:  n_idx = r_idx + AW'(1);
        endcase
    end

    always_comb begin
        unique case (i_cmd_bus.wa_sel)
            prq_pkg::WA_INC: wr_addr = r_idx + AW'(1);
            prq_pkg::WA_DEC: wr_addr = r_idx - AW'(1);
            default:         wr_addr = '0;
        endcase
        wr_data = (i_cmd_bus.wd_sel == prq_pkg::WD_READ) ? rd_data : {r_new_id, r_new_pri};
    end

    prq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd_bus.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd_bus.rd_en),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    // index and captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.rd_en) begin
            r_idx <= n_idx;
        end
        if (i_cmd_bus.capture) begin
            r_op      <= i_cmd;
            r_new_id  <= i_proc_id;
            r_new_pri <= PRIORITY_BITS'(i_priority_req);
        end
    end

    // result being built
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_ok     <= 1'b0;
            r_res_status <= prq_pkg::ST_OK;
        end else if (i_cmd_bus.capture) begin
            r_res_ok     <= 1'b0;
            r_res_status <= prq_pkg::ST_OK;
        end else if (i_cmd_bus.take_head) begin
            r_res_ok     <= 1'b1;
        end else if (i_cmd_bus.set_status) begin
            r_res_status <= i_cmd_bus.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.capture) begin
            r_res_id  <= '0;
            r_res_pri <= '0;
        end else if (i_cmd_bus.take_head) begin
            r_res_id  <= rd_id;
            r_res_pri <= rd_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd_bus.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd_bus.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    // output register, parts the queue from the result consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd_bus.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.out_load) begin
            r_o_ok     <= r_res_ok;
            r_o_id     <= r_res_id;
            r_o_pri    <= prq_pkg::OutPriBits'(r_res_pri);
            r_o_status <= r_res_status;
            r_o_count  <= prq_pkg::CountBits'(r_count);
        end
    end

    assign o_stat.is_remove = (r_op == prq_pkg::CMD_REMOVE);
    assign o_stat.full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.count_one = (r_count == CW'(1));
    assign o_stat.lower     = (rd_pri < r_new_pri);
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.idx_last  = (r_idx == last_idx);
    assign o_stat.out_busy  = r_o_valid && i_res_stall;

    assign o_res_valid    = r_o_valid;
    assign o_out_valid    = r_o_ok;
    assign o_out_proc_id  = r_o_id;
    assign o_out_priority = r_o_pri;
    assign o_status       = r_o_status;
    assign o_entry_count  = r_o_count;

endmodule

[design/prq_ctrl.sv]
// controller: sequences one insert or remove pass over the entry store
// depends on prq_pkg
module prq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  prq_pkg::t_prq_stat i_stat,
    output prq_pkg::t_prq_cmd  o_cmd_bus
);

    prq_pkg::t_prq_state r_state;
    prq_pkg::t_prq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state             = r_state;
        o_cmd_bus           = '0;
        o_cmd_bus.rd_sel    = prq_pkg::RD_ZERO;
        o_cmd_bus.wa_sel    = prq_pkg::WA_ZERO;
        o_cmd_bus.wd_sel    = prq_pkg::WD_NEW;
        o_cmd_bus.status    = prq_pkg::ST_OK;
        o_in_stall          = 1'b1;
        unique case (r_state)
            prq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd_bus.capture = 1'b1;
                    n_state = prq_pkg::S_DECODE;
                end
            end
            prq_pkg::S_DECODE: begin
                if (!i_stat.is_remove) begin
                    if (i_stat.full) begin
                        o_cmd_bus.set_status = 1'b1;
                        o_cmd_bus.status     = prq_pkg::ST_FULL;
                        n_state = prq_pkg::S_FIN;
                    end else if (i_stat.empty) begin
                        o_cmd_bus.wr_en   = 1'b1;
                        o_cmd_bus.cnt_inc = 1'b1;
                        n_state = prq_pkg::S_FIN;
                    end else begin
                        // walk back from the tail
                        o_cmd_bus.rd_en  = 1'b1;
                        o_cmd_bus.rd_sel = prq_pkg::RD_LAST;
                        n_state = prq_pkg::S_INS_LOOP;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd_bus.set_status = 1'b1;
                        o_cmd_bus.status     = prq_pkg::ST_EMPTY;
                        n_state = prq_pkg::S_FIN;
                    end else begin
                        o_cmd_bus.rd_en = 1'b1;
                        n_state = prq_pkg::S_REM_HEAD;
                    end
                end
            end
            prq_pkg::S_INS_LOOP: begin
                o_cmd_bus.wr_en  = 1'b1;
                o_cmd_bus.wa_sel = prq_pkg::WA_INC;
                if (i_stat.lower) begin
                    // lower priority entry moves one slot back
                    o_cmd_bus.wd_sel = prq_pkg::WD_READ;
                    if (i_stat.idx_zero) begin
                        n_state = prq_pkg::S_INS_PUT0;
                    end else begin
                        o_cmd_bus.rd_en  = 1'b1;
                        o_cmd_bus.rd_sel = prq_pkg::RD_DEC;
                    end
                end else begin
                    o_cmd_bus.cnt_inc = 1'b1;
                    n_state = prq_pkg::S_FIN;
                end
            end
            prq_pkg::S_INS_PUT0: begin
                o_cmd_bus.wr_en   = 1'b1;
                o_cmd_bus.cnt_inc = 1'b1;
                n_state = prq_pkg::S_FIN;
            end
            prq_pkg::S_REM_HEAD: begin
                o_cmd_bus.take_head = 1'b1;
                if (i_stat.count_one) begin
                    o_cmd_bus.cnt_dec = 1'b1;
                    n_state = prq_pkg::S_FIN;
                end else begin
                    o_cmd_bus.rd_en  = 1'b1;
                    o_cmd_bus.rd_sel = prq_pkg::RD_INC;
                    n_state = prq_pkg::S_REM_LOOP;
                end
            end
            prq_pkg::S_REM_LOOP: begin
                o_cmd_bus.wr_en  = 1'b1;
                o_cmd_bus.wa_sel = prq_pkg::WA_DEC;
                o_cmd_bus.wd_sel = prq_pkg::WD_READ;
                if (i_stat.idx_last) begin
                    o_cmd_bus.cnt_dec = 1'b1;
                    n_state = prq_pkg::S_FIN;
                end else begin
                    o_cmd_bus.rd_en  = 1'b1;
                    o_cmd_bus.rd_sel = prq_pkg::RD_INC;
                end
            end
            prq_pkg::S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd_bus.out_load = 1'b1;
                    n_state = prq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/priority_ready_queue_top.sv]
// priority ready queue: an insert moves each entry of lower priority one slot back (up to
// QUEUE_DEPTH - 1 entries) and writes the new entry; a remove takes the head and moves each
// later entry one slot forward; full or empty commands only set the status. one command at
// a time, one read and one write a cycle on the entry memory; a held result adds its stall.
// the output register lets the next command start while a result waits.
// synchronous active-low reset empties the queue; memory contents are not cleared.
module priority_ready_queue_top #(
    parameter int unsigned QUEUE_DEPTH   = 16,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [3:0] i_proc_id,
    input  logic [7:0] i_priority_req,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic       o_out_valid,
    output logic [3:0] o_out_proc_id,
    output logic [7:0] o_out_priority,
    output logic [1:0] o_status,
    output logic [4:0] o_entry_count
);

    prq_pkg::t_prq_cmd  cmd_bus;
    prq_pkg::t_prq_stat stat;

    prq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd_bus  (cmd_bus)
    );

    prq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (cmd_bus),
        .o_stat         (stat),
        .i_cmd          (i_cmd),
        .i_proc_id      (i_proc_id),
        .i_priority_req (i_priority_req),
        .i_res_stall    (i_res_stall),
        .o_res_valid    (o_res_valid),
        .o_out_valid    (o_out_valid),
        .o_out_proc_id  (o_out_proc_id),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

endmodule

[tb/priority_ready_queue_top_tb.sv]
// self-checking testbench for priority_ready_queue_top: directed and random insert/remove
// traffic, checked against a sorted-store predictor kept alongside the block
// depends on prq_pkg and priority_ready_queue_top
module priority_ready_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth     = 16;
    localparam int NumRandom = 1700;

    typedef struct {
        prq_pkg::t_prq_op op;
        logic [3:0]       pid;
        logic [7:0]       pri;
        bit               settle;  // hold back until every outstanding result is back
    } t_sched_cmd;

    typedef struct {
        logic                 taken;
        logic [3:0]           pid;
        logic [7:0]           pri;
        prq_pkg::t_prq_status status;
        logic [4:0]           count;
    } t_sched_result;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    prq_pkg::t_prq_op cmd = prq_pkg::CMD_INSERT;
    logic [3:0]       pid = '0;
    logic [7:0]       pri = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    logic             o_out_valid;
    logic [3:0]       o_out_proc_id;
    logic [7:0]       o_out_priority;
    logic [1:0]       o_status;
    logic [4:0]       o_entry_count;

    t_sched_cmd    pending[$];
    t_sched_result awaited[$];
    int            errors = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            cycle_no = 0;
    logic          winding_down = 1'b0;

    // ready queue as the testbench sees it, head at slot 0
    logic [3:0] queue_ids  [Depth];
    logic [7:0] queue_pris [Depth];
    int         queue_fill = 0;

    priority_ready_queue_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_proc_id      (pid),
        .i_priority_req (pri),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_out_valid    (o_out_valid),
        .o_out_proc_id  (o_out_proc_id),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic t_sched_result schedule_step(prq_pkg::t_prq_op op,
                                                    logic [3:0] id,
                                                    logic [7:0] prio);
        t_sched_result r;
        int            slot;
        bit            found;
        r = '{taken: 1'b0, pid: '0, pri: '0, status: prq_pkg::ST_OK, count: '0};
        if (op == prq_pkg::CMD_INSERT) begin
            if (queue_fill >= Depth) begin
                r.status = prq_pkg::ST_FULL;
            end else begin
                // new entry goes behind everything of greater or equal priority
                slot  = queue_fill;
                found = 1'b0;
                for (int i = 0; i < queue_fill; i++) begin
                    if (!found && queue_pris[i] < prio) begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                for (int i = queue_fill; i > slot; i--) begin
                    queue_ids[i]  = queue_ids[i - 1];
                    queue_pris[i] = queue_pris[i - 1];
                end
                queue_ids[slot]  = id;
                queue_pris[slot] = prio;
                queue_fill++;
            end
        end else if (queue_fill == 0) begin
            r.status = prq_pkg::ST_EMPTY;
        end else begin
            r.taken = 1'b1;
            r.pid   = queue_ids[0];
            r.pri   = queue_pris[0];
            for (int i = 1; i < queue_fill; i++) begin
                queue_ids[i - 1]  = queue_ids[i];
                queue_pris[i - 1] = queue_pris[i];
            end
            queue_fill--;
        end
        r.count = 5'(queue_fill);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic queue_cmd(prq_pkg::t_prq_op op, logic [3:0] id, logic [7:0] prio);
        pending.push_back('{op, id, prio, 1'b0});
    endtask

    // driver: one transaction in flight, random gaps between transactions
    always @(posedge clk) begin
        t_sched_cmd nxt;
        logic       busy;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                awaited.push_back(schedule_step(cmd, pid, pri));
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending.size() != 0 &&
                             !(pending[0].settle && awaited.size() != 0)) begin
                    nxt = pending.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= nxt.op;
                    pid      <= nxt.pid;
                    pri      <= nxt.pri;
                    if (!winding_down && $urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(1, 14);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
            winding_down <= (pending.size() < 120);
        end
    end

    // result side stalls: random bursts, one long hold-off to back the queue up
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            stall_left = 0;
            cycle_no   = 0;
        end else begin
            cycle_no++;
            if (cycle_no == 2000) begin
                stall_left = 500;
            end else if (stall_left == 0 && !winding_down && (cycle_no % 3000) < 2000 &&
                         $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                res_stall <= 1'b1;
                stall_left--;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        t_sched_result want;
        if (rst_n && res_valid && !res_stall) begin
            if (awaited.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = awaited.pop_front();
                compare_field("out_valid", 8'(o_out_valid), 8'(want.taken));
                compare_field("out_proc_id", 8'(o_out_proc_id), 8'(want.pid));
                compare_field("out_priority", o_out_priority, want.pri);
                compare_field("status", 8'(o_status), 8'(want.status));
                compare_field("entry_count", 8'(o_entry_count), 8'(want.count));
            end
        end
    end

    initial begin
        t_sched_cmd item;
        logic [7:0] fill_pris [13];
        int         seg_len;
        int         ins_pct;
        int         base;
        bit         narrow;
        int         n;

        // directed: empty remove, extremes, ties, fill to full, insert when full
        fill_pris = '{8'd255, 8'd0, 8'd128, 8'd200, 8'd200, 8'd1, 8'd254,
                      8'd127, 8'd129, 8'd0, 8'd255, 8'd64, 8'd64};
        queue_cmd(prq_pkg::CMD_REMOVE, 4'd9, 8'd99);
        queue_cmd(prq_pkg::CMD_INSERT, 4'd15, 8'd255);
        queue_cmd(prq_pkg::CMD_INSERT, 4'd0, 8'd0);
        queue_cmd(prq_pkg::CMD_INSERT, 4'd5, 8'd128);
        queue_cmd(prq_pkg::CMD_INSERT, 4'd6, 8'd128);
        queue_cmd(prq_pkg::CMD_REMOVE, 4'd0, 8'd0);
        for (int k = 0; k < 13; k++) begin
            queue_cmd(prq_pkg::CMD_INSERT, 4'(k + 1), fill_pris[k]);
        end
        queue_cmd(prq_pkg::CMD_INSERT, 4'd14, 8'd255);
        for (int k = 0; k < 4; k++) begin
            queue_cmd(prq_pkg::CMD_REMOVE, 4'hf, 8'hff);
        end

        // random: segments leaning towards filling, draining or holding level
        n = 0;
        while (n < NumRandom) begin
            seg_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0:       ins_pct = 15;
                1:       ins_pct = 50;
                default: ins_pct = 85;
            endcase
            narrow = $urandom_range(0, 1);
            base   = $urandom_range(0, 252);
            for (int k = 0; k < seg_len && n < NumRandom; k++) begin
                item.op  = ($urandom_range(1, 100) <= ins_pct) ? prq_pkg::CMD_INSERT
                                                               : prq_pkg::CMD_REMOVE;
                item.pid = 4'($urandom);
                if (narrow) begin
                    item.pri = 8'(base + $urandom_range(0, 3));
                end else if ($urandom_range(0, 9) == 0) begin
                    item.pri = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end else begin
                    item.pri = 8'($urandom);
                end
                item.settle = (n == 0 || n == NumRandom / 2);
                pending.push_back(item);
                n++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        do begin
            @(posedge clk);
        end while (pending.size() != 0 || in_valid || awaited.size() != 0);
        repeat (40) @(posedge clk);
        if (errors == 0) begin
            $display("priority_ready_queue_top_tb: done, clean");
        end else begin
            $display("priority_ready_queue_top_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("priority_ready_queue_top_tb: done, errors");
        $finish;
    end

endmodule
